[sv/bcg_pkg.sv]
// Shared constants, types and a helper function of the corner gradient generator.
`timescale 1ns / 1ps

package bcg_pkg;

	localparam int MAX_DIM       = 4096;
	localparam int FRAC_BITS_DEF = 16;
	localparam int COORD_W       = 12;
	localparam int DIM_W         = 13;
	localparam int REM_W         = DIM_W + 1;
	localparam int CHAN_W        = 8;
	localparam int RGB_W         = 3 * CHAN_W;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = RGB_W;

	localparam logic [RGB_W-1:0] RST_TOP_LEFT     = 24'h00FF00;
	localparam logic [RGB_W-1:0] RST_TOP_RIGHT    = 24'hFF0000;
	localparam logic [RGB_W-1:0] RST_BOTTOM_LEFT  = 24'h800080;
	localparam logic [RGB_W-1:0] RST_BOTTOM_RIGHT = 24'h0000FF;
	localparam logic [DIM_W-1:0] RST_FRAME_DIM    = 13'd500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_LEFT     = 3'd0,
		REG_TOP_RIGHT    = 3'd1,
		REG_BOTTOM_LEFT  = 3'd2,
		REG_BOTTOM_RIGHT = 3'd3,
		REG_FRAME_WIDTH  = 3'd4,
		REG_FRAME_HEIGHT = 3'd5
	} bcg_reg_t;

	typedef struct packed {
		logic valid;
		logic y_top;
		logic y_bot;
	} bcg_ctl_t;

	// Index of the last column or row for a frame size, with the size held to its legal range.
	function automatic logic [DIM_W-1:0] last_index(input logic [DIM_W-1:0] dim);
		logic [DIM_W-1:0] last;
		if (dim < DIM_W'(2)) begin
			last = DIM_W'(1);
		end else if (32'(dim) > MAX_DIM) begin
			last = DIM_W'(MAX_DIM - 1);
		end else begin
			last = dim - DIM_W'(1);
		end
		return last;
	endfunction

endpackage

[sv/bcg_ifs.sv]
// Handshake interfaces for the pixel request, color result and register write channels.
`timescale 1ns / 1ps

interface bcg_pix_if;
	import bcg_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	modport source(output valid, pixel_x, pixel_y, input ready);
	modport sink(input valid, pixel_x, pixel_y, output ready);
endinterface

interface bcg_rgb_if;
	import bcg_pkg::*;
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;
	modport source(output valid, red_out, green_out, blue_out, input ready);
	modport sink(input valid, red_out, green_out, blue_out, output ready);
endinterface

interface bcg_cfg_if;
	import bcg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[sv/bcg_cell.sv]
// One divider cell: produces one fraction bit for the column and the row and passes the rest on.
`timescale 1ns / 1ps

module bcg_cell #(
	parameter int FRAC_BITS = bcg_pkg::FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [bcg_pkg::DIM_W-1:0] div_x,
	input  logic [bcg_pkg::DIM_W-1:0] div_y,
	input  logic [bcg_pkg::REM_W-1:0] rx_i,
	input  logic [bcg_pkg::REM_W-1:0] ry_i,
	input  logic [FRAC_BITS:0]        qx_i,
	input  logic [FRAC_BITS:0]        qy_i,
	input  bcg_pkg::bcg_ctl_t         ctl_i,
	output logic [bcg_pkg::REM_W-1:0] rx_o,
	output logic [bcg_pkg::REM_W-1:0] ry_o,
	output logic [FRAC_BITS:0]        qx_o,
	output logic [FRAC_BITS:0]        qy_o,
	output bcg_pkg::bcg_ctl_t         ctl_o
);
	import bcg_pkg::*;

	localparam int QW = FRAC_BITS + 1;

	logic             bit_x;
	logic             bit_y;
	logic [REM_W-1:0] dx;
	logic [REM_W-1:0] dy;

	logic [REM_W-1:0] rx_s1;
	logic [REM_W-1:0] ry_s1;
	logic [QW-1:0]    qx_s1;
	logic [QW-1:0]    qy_s1;
	bcg_ctl_t         ctl_s1;

	// Restoring step: subtract the divisor when it fits, then double the remainder.
	always_comb begin
		bit_x = rx_i >= REM_W'(div_x);
		bit_y = ry_i >= REM_W'(div_y);
		dx    = bit_x ? rx_i - REM_W'(div_x) : rx_i;
		dy    = bit_y ? ry_i - REM_W'(div_y) : ry_i;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= {dx[REM_W-2:0], 1'b0};
			ry_s1 <= {dy[REM_W-2:0], 1'b0};
			qx_s1 <= {qx_i[QW-2:0], bit_x};
			qy_s1 <= {qy_i[QW-2:0], bit_y};
		end
	end

	assign rx_o  = rx_s1;
	assign ry_o  = ry_s1;
	assign qx_o  = qx_s1;
	assign qy_o  = qy_s1;
	assign ctl_o = ctl_s1;

endmodule

[sv/bcg_lerp.sv]
// Two-product blend of one color channel by a fixed-point fraction, products registered.
`timescale 1ns / 1ps

module bcg_lerp #(
	parameter int FRAC_BITS = bcg_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [FRAC_BITS:0]        frac,
	input  logic [bcg_pkg::CHAN_W-1:0] a,
	input  logic [bcg_pkg::CHAN_W-1:0] b,
	output logic [bcg_pkg::CHAN_W-1:0] y
);
	import bcg_pkg::*;

	localparam int QW = FRAC_BITS + 1;
	localparam int PW = QW + CHAN_W;
	localparam logic [QW-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};

	logic [QW-1:0]     inv;
	logic [PW-1:0]     prod_a;
	logic [PW-1:0]     prod_b;
	logic [CHAN_W-1:0] pa_s1;
	logic [CHAN_W-1:0] pb_s1;
	logic [CHAN_W:0]   sum;

	always_comb begin
		inv    = ONE_FIX - frac;
		prod_a = PW'(inv) * PW'(a);
		prod_b = PW'(frac) * PW'(b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1 <= prod_a[FRAC_BITS +: CHAN_W];
			pb_s1 <= prod_b[FRAC_BITS +: CHAN_W];
		end
	end

	always_comb begin
		sum = {1'b0, pa_s1} + {1'b0, pb_s1};
		y   = sum[CHAN_W] ? {CHAN_W{1'b1}} : sum[CHAN_W-1:0];
	end

endmodule

[sv/bilinear_corner_gradient_top.sv]
// Four-corner RGB gradient generator: one pixel coordinate in, its interpolated color out.
// A request beat passes through the chain of FRAC_BITS + 1 divider cells, one fraction bit per
// cell, on its way to its result beat.
// Throughput: one beat per cycle unless both output buffer entries are full; the two-entry buffer
// lets the pipeline keep taking beats while a result waits. Reset loads the default corner colors
// and a 500 by 500 frame and empties the pipeline.
`timescale 1ns / 1ps

module bilinear_corner_gradient_top #(
	parameter int FRAC_BITS = bcg_pkg::FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	bcg_pix_if.sink   pix_in,
	bcg_rgb_if.source pix_out,
	bcg_cfg_if.sink   cfg_wr
);
	import bcg_pkg::*;

	localparam int QW    = FRAC_BITS + 1;
	localparam int NCELL = QW;
	localparam logic [QW-1:0] ONE_FIX = {1'b1, {FRAC_BITS{1'b0}}};

	logic [RGB_W-1:0] tl_q;
	logic [RGB_W-1:0] tr_q;
	logic [RGB_W-1:0] bl_q;
	logic [RGB_W-1:0] br_q;
	logic [DIM_W-1:0] last_w_q;
	logic [DIM_W-1:0] last_h_q;

	logic               en;
	logic [COORD_W-1:0] xc;
	logic [COORD_W-1:0] yc;
	bcg_ctl_t           ctl_in;

	bcg_ctl_t         ctl_s1;
	logic [REM_W-1:0] rx_s1;
	logic [REM_W-1:0] ry_s1;

	logic [REM_W-1:0] rx_c  [NCELL];
	logic [REM_W-1:0] ry_c  [NCELL];
	logic [QW-1:0]    qx_c  [NCELL+1];
	logic [QW-1:0]    qy_c  [NCELL+1];
	bcg_ctl_t         ctl_c [NCELL+1];

	logic [CHAN_W-1:0] top_h [3];
	logic [CHAN_W-1:0] bot_h [3];
	logic [CHAN_W-1:0] mid_v [3];
	logic [CHAN_W-1:0] res   [3];

	bcg_ctl_t          ctl_s2;
	logic [QW-1:0]     fy_s2;
	bcg_ctl_t          ctl_s3;
	logic [QW-1:0]     fy_s3;
	logic [CHAN_W-1:0] top_s3 [3];
	logic [CHAN_W-1:0] bot_s3 [3];
	bcg_ctl_t          ctl_s4;
	logic [CHAN_W-1:0] top_s4 [3];
	logic [CHAN_W-1:0] bot_s4 [3];

	logic             push;
	logic             pop;
	logic [RGB_W-1:0] res_rgb;
	logic [RGB_W-1:0] head_q;
	logic             head_v_q;
	logic [RGB_W-1:0] skid_q;
	logic             skid_v_q;

	// Register file. Frame sizes are kept as the index of the last column and row.
	assign cfg_wr.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tl_q     <= RST_TOP_LEFT;
			tr_q     <= RST_TOP_RIGHT;
			bl_q     <= RST_BOTTOM_LEFT;
			br_q     <= RST_BOTTOM_RIGHT;
			last_w_q <= last_index(RST_FRAME_DIM);
			last_h_q <= last_index(RST_FRAME_DIM);
		end else if (cfg_wr.valid) begin
			case (bcg_reg_t'(cfg_wr.index))
				REG_TOP_LEFT:     tl_q     <= cfg_wr.data;
				REG_TOP_RIGHT:    tr_q     <= cfg_wr.data;
				REG_BOTTOM_LEFT:  bl_q     <= cfg_wr.data;
				REG_BOTTOM_RIGHT: br_q     <= cfg_wr.data;
				REG_FRAME_WIDTH:  last_w_q <= last_index(cfg_wr.data[DIM_W-1:0]);
				REG_FRAME_HEIGHT: last_h_q <= last_index(cfg_wr.data[DIM_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// The whole pipeline advances unless both output buffer entries are full.
	assign en           = !(head_v_q && skid_v_q);
	assign pix_in.ready = en;

	always_comb begin
		xc = (DIM_W'(pix_in.pixel_x) > last_w_q) ? last_w_q[COORD_W-1:0] : pix_in.pixel_x;
		yc = (DIM_W'(pix_in.pixel_y) > last_h_q) ? last_h_q[COORD_W-1:0] : pix_in.pixel_y;
		ctl_in.valid = pix_in.valid;
		ctl_in.y_top = yc == '0;
		ctl_in.y_bot = (yc != '0) && (DIM_W'(yc) == last_h_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_c[NCELL];
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= REM_W'(xc);
			ry_s1 <= REM_W'(yc);
			fy_s2 <= qy_c[NCELL];
			fy_s3 <= fy_s2;
		end
	end

	assign rx_c[0]  = rx_s1;
	assign ry_c[0]  = ry_s1;
	assign qx_c[0]  = '0;
	assign qy_c[0]  = '0;
	assign ctl_c[0] = ctl_s1;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		if (k == NCELL - 1) begin : g_last
			bcg_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.div_x  (last_w_q),
				.div_y  (last_h_q),
				.rx_i   (rx_c[k]),
				.ry_i   (ry_c[k]),
				.qx_i   (qx_c[k]),
				.qy_i   (qy_c[k]),
				.ctl_i  (ctl_c[k]),
				.rx_o   (),
				.ry_o   (),
				.qx_o   (qx_c[k+1]),
				.qy_o   (qy_c[k+1]),
				.ctl_o  (ctl_c[k+1])
			);
		end else begin : g_mid
			bcg_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.div_x  (last_w_q),
				.div_y  (last_h_q),
				.rx_i   (rx_c[k]),
				.ry_i   (ry_c[k]),
				.qx_i   (qx_c[k]),
				.qy_i   (qy_c[k]),
				.ctl_i  (ctl_c[k]),
				.rx_o   (rx_c[k+1]),
				.ry_o   (ry_c[k+1]),
				.qx_o   (qx_c[k+1]),
				.qy_o   (qy_c[k+1]),
				.ctl_o  (ctl_c[k+1])
			);
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_chan
		localparam int MSB = RGB_W - 1 - CHAN_W * c;

		bcg_lerp #(.FRAC_BITS(FRAC_BITS)) u_top (
			.clk  (clk),
			.en   (en),
			.frac (qx_c[NCELL]),
			.a    (tl_q[MSB -: CHAN_W]),
			.b    (tr_q[MSB -: CHAN_W]),
			.y    (top_h[c])
		);

		bcg_lerp #(.FRAC_BITS(FRAC_BITS)) u_bot (
			.clk  (clk),
			.en   (en),
			.frac (qx_c[NCELL]),
			.a    (bl_q[MSB -: CHAN_W]),
			.b    (br_q[MSB -: CHAN_W]),
			.y    (bot_h[c])
		);

		bcg_lerp #(.FRAC_BITS(FRAC_BITS)) u_vert (
			.clk  (clk),
			.en   (en),
			.frac (fy_s3),
			.a    (top_s3[c]),
			.b    (bot_s3[c]),
			.y    (mid_v[c])
		);

		always_ff @(posedge clk) begin
			if (en) begin
				top_s3[c] <= top_h[c];
				bot_s3[c] <= bot_h[c];
				top_s4[c] <= top_s3[c];
				bot_s4[c] <= bot_s3[c];
			end
		end

		always_comb begin
			if (ctl_s4.y_top) begin
				res[c] = top_s4[c];
			end else if (ctl_s4.y_bot) begin
				res[c] = bot_s4[c];
			end else begin
				res[c] = mid_v[c];
			end
		end
	end

	assign res_rgb = {res[0], res[1], res[2]};
	assign push    = en && ctl_s4.valid;
	assign pop     = head_v_q && pix_out.ready;

	// Two-entry output buffer: the head drives the port, the skid entry catches one more beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop || !head_v_q) begin
			head_v_q <= skid_v_q || push;
			skid_v_q <= skid_v_q && push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop || !head_v_q) begin
			head_q <= skid_v_q ? skid_q : res_rgb;
			skid_q <= res_rgb;
		end else if (push) begin
			skid_q <= res_rgb;
		end
	end

	assign pix_out.valid     = head_v_q;
	assign pix_out.red_out   = head_q[RGB_W-1 -: CHAN_W];
	assign pix_out.green_out = head_q[RGB_W-1-CHAN_W -: CHAN_W];
	assign pix_out.blue_out  = head_q[CHAN_W-1:0];

	a_frac_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[NCELL].valid |-> (qx_c[NCELL] <= ONE_FIX) && (qy_c[NCELL] <= ONE_FIX))
		else $error("fraction from the divider chain exceeds one");

	a_row_flags: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[NCELL].valid |-> !(ctl_c[NCELL].y_top && ctl_c[NCELL].y_bot))
		else $error("pixel marked as both top and bottom row");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(head_v_q) && !$past(pix_out.ready))
		else $error("skid entry filled while the head was free");

	a_head_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(head_v_q && skid_v_q && pix_out.ready) |=> head_v_q)
		else $error("buffered beat lost after the head was taken");

endmodule

[sim/bcg_color_check.sv]
// Watches the request, result and register channels, predicts each color and compares the results.
`timescale 1ns / 1ps

module bcg_color_check (
	input logic clk,
	input logic arst_n,
	bcg_pix_if  pix_in,
	bcg_rgb_if  pix_out,
	bcg_cfg_if  cfg_wr,
	output int  fail_count,
	output int  pending
);
	import bcg_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam longint unsigned ONE_FIX = 64'd1 << FRAC;

	typedef struct {
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} color_beat_t;

	logic [RGB_W-1:0] top_left;
	logic [RGB_W-1:0] top_right;
	logic [RGB_W-1:0] bottom_left;
	logic [RGB_W-1:0] bottom_right;
	logic [DIM_W-1:0] frame_width;
	logic [DIM_W-1:0] frame_height;

	color_beat_t color_q[$];
	int          errors = 0;

	function automatic longint unsigned effective_dim(input logic [DIM_W-1:0] dim);
		if (dim < DIM_W'(2))
			return 2;
		if (32'(dim) > MAX_DIM)
			return MAX_DIM;
		return 64'(dim);
	endfunction

	function automatic logic [CHAN_W-1:0] mix_channel(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b, input longint unsigned f);
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned sum;
		lo  = ((ONE_FIX - f) * a) >> FRAC;
		hi  = (f * b) >> FRAC;
		sum = lo + hi;
		if (sum > 255)
			sum = 255;
		return sum[CHAN_W-1:0];
	endfunction

	function automatic color_beat_t gradient_color(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y);
		color_beat_t       c;
		longint unsigned   w;
		longint unsigned   h;
		longint unsigned   cx;
		longint unsigned   cy;
		longint unsigned   fx;
		longint unsigned   fy;
		logic [CHAN_W-1:0] top;
		logic [CHAN_W-1:0] bot;
		logic [CHAN_W-1:0] level[3];
		w  = effective_dim(frame_width);
		h  = effective_dim(frame_height);
		cx = 64'(x);
		cy = 64'(y);
		if (cx > w - 1)
			cx = w - 1;
		if (cy > h - 1)
			cy = h - 1;
		fx = (cx << FRAC) / (w - 1);
		fy = (cy << FRAC) / (h - 1);
		for (int ch = 0; ch < 3; ch++) begin
			top = mix_channel(top_left[23-8*ch -: 8], top_right[23-8*ch -: 8], fx);
			bot = mix_channel(bottom_left[23-8*ch -: 8], bottom_right[23-8*ch -: 8], fx);
			if (cy == 0)
				level[ch] = top;
			else if (cy == h - 1)
				level[ch] = bot;
			else
				level[ch] = mix_channel(top, bot, fy);
		end
		c.red   = level[0];
		c.green = level[1];
		c.blue  = level[2];
		c.x     = x;
		c.y     = y;
		return c;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		color_beat_t want;
		if (!arst_n) begin
			top_left     = RST_TOP_LEFT;
			top_right    = RST_TOP_RIGHT;
			bottom_left  = RST_BOTTOM_LEFT;
			bottom_right = RST_BOTTOM_RIGHT;
			frame_width  = RST_FRAME_DIM;
			frame_height = RST_FRAME_DIM;
			color_q.delete();
			errors = 0;
		end else begin
			if (pix_out.valid && pix_out.ready) begin
				if (color_q.size() == 0) begin
					report_mismatch($sformatf("color beat %0d/%0d/%0d with no request pending",
						pix_out.red_out, pix_out.green_out, pix_out.blue_out));
				end else begin
					want = color_q.pop_front();
					if (pix_out.red_out !== want.red)
						report_mismatch($sformatf("red at (%0d,%0d): expected %0d, got %0d",
							want.x, want.y, want.red, pix_out.red_out));
					if (pix_out.green_out !== want.green)
						report_mismatch($sformatf("green at (%0d,%0d): expected %0d, got %0d",
							want.x, want.y, want.green, pix_out.green_out));
					if (pix_out.blue_out !== want.blue)
						report_mismatch($sformatf("blue at (%0d,%0d): expected %0d, got %0d",
							want.x, want.y, want.blue, pix_out.blue_out));
				end
			end
			if (pix_in.valid && pix_in.ready)
				color_q.push_back(gradient_color(pix_in.pixel_x, pix_in.pixel_y));
			if (cfg_wr.valid && cfg_wr.ready) begin
				case (cfg_wr.index)
					REG_TOP_LEFT:     top_left     = cfg_wr.data;
					REG_TOP_RIGHT:    top_right    = cfg_wr.data;
					REG_BOTTOM_LEFT:  bottom_left  = cfg_wr.data;
					REG_BOTTOM_RIGHT: bottom_right = cfg_wr.data;
					REG_FRAME_WIDTH:  frame_width  = cfg_wr.data[DIM_W-1:0];
					REG_FRAME_HEIGHT: frame_height = cfg_wr.data[DIM_W-1:0];
					default: ;
				endcase
			end
		end
		pending    <= color_q.size();
		fail_count <= errors;
	end

endmodule

[sim/bilinear_corner_gradient_top_tb.sv]
// Top of the gradient generator testbench: reset, register settings, pixel traffic and verdict.
`timescale 1ns / 1ps

module bilinear_corner_gradient_top_tb;
	import bcg_pkg::*;

	localparam int LATENCY         = FRAC_BITS_DEF + 5;
	localparam int DRAIN_CYCLES    = 2 * LATENCY + 8;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int PHASES          = 12;
	localparam int ITEMS_PER_PHASE = 136;
	localparam int HOLD_CYCLES     = 400;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	bcg_pix_if pix_in();
	bcg_rgb_if pix_out();
	bcg_cfg_if cfg_wr();

	int          fail_count;
	int          pending;
	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          hold_requests  = 0;
	int          hold_served    = 0;
	int          hold_left      = 0;
	int unsigned cur_w          = 500;
	int unsigned cur_h          = 500;

	bilinear_corner_gradient_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix_in (pix_in),
		.pix_out(pix_out),
		.cfg_wr (cfg_wr)
	);

	bcg_color_check i_color_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.pix_out   (pix_out),
		.cfg_wr    (cfg_wr),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		pix_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pix_out.ready <= 1'b0;
			end else begin
				pix_out.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("bilinear_corner_gradient_top_tb failed");
		$finish;
	end

	task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_in.valid <= 1'b0;
			@(posedge clk);
		end
		pix_in.valid   <= 1'b1;
		pix_in.pixel_x <= x;
		pix_in.pixel_y <= y;
		@(posedge clk);
		while (!pix_in.ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wr.valid <= 1'b1;
		cfg_wr.index <= idx;
		cfg_wr.data  <= value;
		@(posedge clk);
		while (!cfg_wr.ready) @(posedge clk);
		cfg_wr.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_corners(input logic [RGB_W-1:0] tl, input logic [RGB_W-1:0] tr,
			input logic [RGB_W-1:0] bl, input logic [RGB_W-1:0] br);
		write_reg(REG_TOP_LEFT, tl);
		write_reg(REG_TOP_RIGHT, tr);
		write_reg(REG_BOTTOM_LEFT, bl);
		write_reg(REG_BOTTOM_RIGHT, br);
	endtask

	task automatic set_frame(input logic [CFG_DATA_W-1:0] raw_w, input logic [CFG_DATA_W-1:0] raw_h);
		write_reg(REG_FRAME_WIDTH, raw_w);
		write_reg(REG_FRAME_HEIGHT, raw_h);
		cur_w = 32'(raw_w[DIM_W-1:0]);
		cur_h = 32'(raw_h[DIM_W-1:0]);
		if (cur_w < 2)
			cur_w = 2;
		if (cur_w > MAX_DIM)
			cur_w = MAX_DIM;
		if (cur_h < 2)
			cur_h = 2;
		if (cur_h > MAX_DIM)
			cur_h = MAX_DIM;
	endtask

	function automatic logic [COORD_W-1:0] pick_coord(input int unsigned dim);
		int unsigned c;
		case ($urandom_range(0, 7))
			0: c = 0;
			1: c = dim - 1;
			2: c = dim - 2;
			3: c = $urandom_range(0, 4095);
			4: c = dim + $urandom_range(0, 3);
			default: c = $urandom_range(0, dim - 1);
		endcase
		if (c > 4095)
			c = 4095;
		return COORD_W'(c);
	endfunction

	initial begin
		pix_in.valid   = 1'b0;
		pix_in.pixel_x = '0;
		pix_in.pixel_y = '0;
		cfg_wr.valid   = 1'b0;
		cfg_wr.index   = REG_TOP_LEFT;
		cfg_wr.data    = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset colors and frame, corners and saturated coordinates.
		send_pixel(0, 0);
		send_pixel(499, 0);
		send_pixel(0, 499);
		send_pixel(499, 499);
		send_pixel(4095, 4095);
		send_pixel(250, 250);
		send_pixel(498, 1);
		wait_drained();

		set_corners(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF);
		set_frame(2, 2);
		send_pixel(0, 0);
		send_pixel(1, 1);
		send_pixel(0, 1);
		send_pixel(1, 0);
		send_pixel(4095, 4095);
		wait_drained();

		set_corners(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
		set_frame(8191, 4096);
		send_pixel(4095, 4094);
		send_pixel(2048, 1);
		send_pixel(4095, 4095);
		send_pixel(0, 2048);
		wait_drained();

		set_frame(0, 1);
		write_reg(REG_SPARE_LO, 24'hFFFFFF);
		write_reg(REG_SPARE_HI, 24'h000003);
		send_pixel(1, 0);
		send_pixel(0, 1);
		send_pixel(4095, 0);
		wait_drained();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			if (phase == 4)
				set_corners(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF);
			else if (phase == 5)
				set_corners(24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000);
			else
				set_corners(RGB_W'($urandom), RGB_W'($urandom), RGB_W'($urandom),
					RGB_W'($urandom));
			case (phase % 6)
				0: set_frame(CFG_DATA_W'($urandom_range(2, 16)),
					CFG_DATA_W'($urandom_range(2, 16)));
				1: set_frame(CFG_DATA_W'($urandom_range(2, 4096)),
					CFG_DATA_W'($urandom_range(2, 4096)));
				2: set_frame(2, 4096);
				3: set_frame(4096, CFG_DATA_W'($urandom_range(2, 40)));
				4: set_frame(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
				default: set_frame(CFG_DATA_W'($urandom_range(0, 1)),
					CFG_DATA_W'($urandom_range(4097, 8191)));
			endcase
			write_reg((phase % 2) ? REG_SPARE_HI : REG_SPARE_LO, CFG_DATA_W'($urandom));
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (phase == 0 && n == 20)
					hold_requests++;
				if (phase == 2 && n == 70)
					wait_drained();
				send_pixel(pick_coord(cur_w), pick_coord(cur_h));
			end
			wait_drained();
		end

		if (fail_count == 0)
			$display("bilinear_corner_gradient_top_tb passed");
		else
			$display("bilinear_corner_gradient_top_tb failed");
		$finish;
	end

endmodule
